// File: design/qpd_pkg.sv
`default_nettype none
package qpd_pkg;

    localparam int POS_WIDTH = 32;
    localparam int TGT_W     = 32;
    localparam int OUT_W     = 32;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ERR_W     = ((POS_WIDTH > TGT_W) ? POS_WIDTH : TGT_W) + 1;
    localparam int DER_W     = ERR_W + 1;
    localparam int SUM_W     = DER_W + GAIN_W + 1;
    localparam int FRAC_W    = 10;
    localparam int MAG_W     = SUM_W - FRAC_W;
    localparam int MCNT_W    = $clog2(GAIN_W);
    localparam int DUTY_W    = 8;
    localparam int RNG_W     = 11;
    localparam int NUM_W     = 22;
    localparam int DCNT_W    = $clog2(DUTY_W);

    localparam int DUTY_LOW  = 125;
    localparam int DUTY_HIGH = 1250;
    localparam int DUTY_MAX  = 255;
    localparam int DUTY_MUL  = 2000;
    localparam int DUTY_RND  = 4902;
    localparam int DUTY_DIV  = 9804;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ONLY = 2'd2;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam logic CHAN_A   = 1'b0;

    typedef struct packed {
        logic                    req_type;
        logic                    channel;
        logic [1:0]              level;
        logic signed [TGT_W-1:0] target;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] position;
        logic                    direction;
        logic [DUTY_W-1:0]       duty;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
    } duty_req_t;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] duty;
    } duty_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_D,
        ST_ABS,
        ST_MAP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_RANGE,
        DS_DIV
    } dstate_t;

endpackage
`default_nettype wire

// File: design/qpd_duty_map.sv
`default_nettype none
module qpd_duty_map (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire qpd_pkg::duty_req_t  req,
    output qpd_pkg::duty_res_t       res
);

    qpd_pkg::dstate_t                  dstate_reg, dstate_next;
    logic [qpd_pkg::MAG_W-1:0]         mag_reg, mag_next;
    logic [qpd_pkg::NUM_W-1:0]         num_reg, num_next;
    logic [qpd_pkg::NUM_W-1:0]         dvs_reg, dvs_next;
    logic [qpd_pkg::DUTY_W-1:0]        quot_reg, quot_next;
    logic [qpd_pkg::DCNT_W-1:0]        cnt_reg, cnt_next;
    logic                              done_reg, done_next;
    logic [qpd_pkg::DUTY_W-1:0]        duty_reg, duty_next;
    logic                              ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg <= qpd_pkg::DS_IDLE;
            done_reg   <= 1'b0;
        end else begin
            dstate_reg <= dstate_next;
            done_reg   <= done_next;
        end
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        duty_reg <= duty_next;
    end

    assign ge = (num_reg >= dvs_reg);

    always_comb begin
        dstate_next = dstate_reg;
        mag_next    = mag_reg;
        num_next    = num_reg;
        dvs_next    = dvs_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        duty_next   = duty_reg;
        case (dstate_reg)
            qpd_pkg::DS_IDLE: begin
                if (req.start) begin
                    mag_next    = req.mag;
                    dstate_next = qpd_pkg::DS_RANGE;
                end
            end
            qpd_pkg::DS_RANGE: begin
                if (mag_reg >= qpd_pkg::MAG_W'(qpd_pkg::DUTY_HIGH)) begin
                    duty_next   = qpd_pkg::DUTY_W'(qpd_pkg::DUTY_MAX);
                    done_next   = 1'b1;
                    dstate_next = qpd_pkg::DS_IDLE;
                end else if (mag_reg < qpd_pkg::MAG_W'(qpd_pkg::DUTY_LOW)) begin
                    duty_next   = '0;
                    done_next   = 1'b1;
                    dstate_next = qpd_pkg::DS_IDLE;
                end else begin
                    num_next    = qpd_pkg::NUM_W'(mag_reg[qpd_pkg::RNG_W-1:0])
                                * qpd_pkg::NUM_W'(qpd_pkg::DUTY_MUL)
                                + qpd_pkg::NUM_W'(qpd_pkg::DUTY_RND);
                    dvs_next    = qpd_pkg::NUM_W'(qpd_pkg::DUTY_DIV)
                                << (qpd_pkg::DUTY_W - 1);
                    quot_next   = '0;
                    cnt_next    = '0;
                    dstate_next = qpd_pkg::DS_DIV;
                end
            end
            qpd_pkg::DS_DIV: begin
                if (ge) begin
                    num_next = num_reg - dvs_reg;
                end
                quot_next = {quot_reg[qpd_pkg::DUTY_W-2:0], ge};
                dvs_next  = dvs_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == qpd_pkg::DCNT_W'(qpd_pkg::DUTY_W - 1)) begin
                    duty_next   = {quot_reg[qpd_pkg::DUTY_W-2:0], ge};
                    done_next   = 1'b1;
                    dstate_next = qpd_pkg::DS_IDLE;
                end
            end
            default: begin
                dstate_next = qpd_pkg::DS_IDLE;
            end
        endcase
    end

    assign res.done = done_reg;
    assign res.duty = duty_reg;

endmodule
`default_nettype wire

// File: design/quadrature_pd_motor_position_drive.sv
// Edge, timeout, feedback-only tick: the beat goes from ST_IDLE through ST_EMIT to the output.
// Control tick: ST_ERR, ST_MUL_P, ST_MUL_D, ST_ABS, ST_MAP, ST_EMIT; the duty map skips its division
// when the duty clamps to 0 or 255. The serial MAC walks 16 gain bits per product and the
// divider retires one quotient bit per cycle. One item in flight; a result waiting in the
// output register stalls the next one. Synchronous active-low reset clears position, levels,
// previous error, drive and gains (gain_prop 5.0); no clearing pass.
`default_nettype none
module quadrature_pd_motor_position_drive (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire qpd_pkg::in_t                     s_data,
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      qpd_pkg::out_t                    m_data,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [qpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [qpd_pkg::CFG_W-1:0]        cfg_data
);

    qpd_pkg::state_t                         state_reg, state_next;
    logic [qpd_pkg::GAIN_W-1:0]              gp_reg, gp_next;
    logic [qpd_pkg::GAIN_W-1:0]              gd_reg, gd_next;
    logic                                    fb_reg, fb_next;
    logic                                    last_a_reg, last_a_next;
    logic                                    last_b_reg, last_b_next;
    logic signed [qpd_pkg::POS_WIDTH-1:0]    pos_reg, pos_next;
    logic signed [qpd_pkg::ERR_W-1:0]        perr_reg, perr_next;
    logic                                    dir_reg, dir_next;
    logic [qpd_pkg::DUTY_W-1:0]              duty_reg, duty_next;
    logic signed [qpd_pkg::TGT_W-1:0]        tgt_reg, tgt_next;
    logic signed [qpd_pkg::ERR_W-1:0]        err_reg, err_next;
    logic signed [qpd_pkg::SUM_W-1:0]        op_reg, op_next;
    logic signed [qpd_pkg::SUM_W-1:0]        acc_reg, acc_next;
    logic [qpd_pkg::GAIN_W-1:0]              gsh_reg, gsh_next;
    logic [qpd_pkg::MCNT_W-1:0]              cnt_reg, cnt_next;
    logic                                    m_valid_reg, m_valid_next;
    qpd_pkg::out_t                           m_data_reg, m_data_next;

    logic                                    s_fire;
    logic                                    up;
    logic signed [qpd_pkg::ERR_W-1:0]        err_calc;
    logic signed [qpd_pkg::DER_W-1:0]        der_calc;
    logic signed [qpd_pkg::SUM_W-1:0]        acc_add;
    logic [qpd_pkg::SUM_W-1:0]               abs_val;
    logic signed [63:0]                      pos_ext;
    qpd_pkg::duty_req_t                      duty_req;
    qpd_pkg::duty_res_t                      duty_res;

    qpd_duty_map u_duty (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (duty_req),
        .res     (duty_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= qpd_pkg::ST_IDLE;
            gp_reg      <= qpd_pkg::GAIN_W'(5120);
            gd_reg      <= '0;
            fb_reg      <= 1'b0;
            last_a_reg  <= 1'b0;
            last_b_reg  <= 1'b0;
            pos_reg     <= '0;
            perr_reg    <= '0;
            dir_reg     <= 1'b0;
            duty_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gp_reg      <= gp_next;
            gd_reg      <= gd_next;
            fb_reg      <= fb_next;
            last_a_reg  <= last_a_next;
            last_b_reg  <= last_b_next;
            pos_reg     <= pos_next;
            perr_reg    <= perr_next;
            dir_reg     <= dir_next;
            duty_reg    <= duty_next;
            m_valid_reg <= m_valid_next;
        end
        tgt_reg    <= tgt_next;
        err_reg    <= err_next;
        op_reg     <= op_next;
        acc_reg    <= acc_next;
        gsh_reg    <= gsh_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = (state_reg == qpd_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign up       = (s_data.channel == qpd_pkg::CHAN_A) ? (s_data.level[0] != last_b_reg)
                                                          : (s_data.level[0] == last_a_reg);
    assign err_calc = qpd_pkg::ERR_W'(tgt_reg) - qpd_pkg::ERR_W'(pos_reg);
    assign der_calc = qpd_pkg::DER_W'(err_reg) - qpd_pkg::DER_W'(perr_reg);
    assign acc_add  = acc_reg + (gsh_reg[0] ? op_reg : '0);
    assign abs_val  = acc_reg[qpd_pkg::SUM_W-1] ? qpd_pkg::SUM_W'(-acc_reg)
                                                : qpd_pkg::SUM_W'(acc_reg);
    assign pos_ext  = 64'(pos_reg);

    assign duty_req.start = (state_reg == qpd_pkg::ST_ABS);
    assign duty_req.mag   = abs_val[qpd_pkg::SUM_W-1:qpd_pkg::FRAC_W];

    always_comb begin
        gp_next = gp_reg;
        gd_next = gd_reg;
        fb_next = fb_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                qpd_pkg::CFG_GAIN_PROP:     gp_next = cfg_data;
                qpd_pkg::CFG_GAIN_DERIV:    gd_next = cfg_data;
                qpd_pkg::CFG_FEEDBACK_ONLY: fb_next = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        last_a_next  = last_a_reg;
        last_b_next  = last_b_reg;
        pos_next     = pos_reg;
        perr_next    = perr_reg;
        dir_next     = dir_reg;
        duty_next    = duty_reg;
        tgt_next     = tgt_reg;
        err_next     = err_reg;
        op_next      = op_reg;
        acc_next     = acc_reg;
        gsh_next     = gsh_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            qpd_pkg::ST_IDLE: begin
                if (s_fire) begin
                    tgt_next   = s_data.target;
                    state_next = qpd_pkg::ST_EMIT;
                    if (s_data.req_type == qpd_pkg::REQ_EDGE) begin
                        if (!s_data.level[1]) begin
                            if (s_data.channel == qpd_pkg::CHAN_A) begin
                                last_a_next = s_data.level[0];
                            end else begin
                                last_b_next = s_data.level[0];
                            end
                            pos_next = up ? pos_reg + 1'b1 : pos_reg - 1'b1;
                        end
                    end else if (!fb_reg) begin
                        state_next = qpd_pkg::ST_ERR;
                    end
                end
            end
            qpd_pkg::ST_ERR: begin
                err_next   = err_calc;
                op_next    = qpd_pkg::SUM_W'(err_calc);
                gsh_next   = gp_reg;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = qpd_pkg::ST_MUL_P;
            end
            qpd_pkg::ST_MUL_P: begin
                acc_next = acc_add;
                op_next  = op_reg <<< 1;
                gsh_next = gsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == qpd_pkg::MCNT_W'(qpd_pkg::GAIN_W - 1)) begin
                    op_next    = qpd_pkg::SUM_W'(der_calc);
                    gsh_next   = gd_reg;
                    cnt_next   = '0;
                    state_next = qpd_pkg::ST_MUL_D;
                end
            end
            qpd_pkg::ST_MUL_D: begin
                acc_next = acc_add;
                op_next  = op_reg <<< 1;
                gsh_next = gsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == qpd_pkg::MCNT_W'(qpd_pkg::GAIN_W - 1)) begin
                    state_next = qpd_pkg::ST_ABS;
                end
            end
            qpd_pkg::ST_ABS: begin
                perr_next  = err_reg;
                dir_next   = !acc_reg[qpd_pkg::SUM_W-1] && (acc_reg != '0);
                state_next = qpd_pkg::ST_MAP;
            end
            qpd_pkg::ST_MAP: begin
                if (duty_res.done) begin
                    duty_next  = duty_res.duty;
                    state_next = qpd_pkg::ST_EMIT;
                end
            end
            qpd_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.position  = pos_ext[qpd_pkg::OUT_W-1:0];
                    m_data_next.direction = dir_reg;
                    m_data_next.duty      = duty_reg;
                    state_next            = qpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qpd_pkg::ST_IDLE;
            end
        endcase
    end

    a_level_a_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.req_type == qpd_pkg::REQ_EDGE && !s_data.level[1]
         && s_data.channel == qpd_pkg::CHAN_A)
        |=> last_a_reg == $past(s_data.level[0]))
        else $error("channel A level not recorded");

    a_pos_only_on_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(pos_reg))
        else $error("position moved without an edge beat");

    a_duty_done_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_res.done |-> state_reg == qpd_pkg::ST_MAP)
        else $error("duty result outside mapping phase");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qpd_pkg::ST_EMIT && (!m_valid_reg || m_ready))
        |=> m_valid_reg && state_reg == qpd_pkg::ST_IDLE)
        else $error("result not presented after completion");

endmodule
`default_nettype wire

// File: verif/quadrature_pd_motor_position_drive_test.sv
`default_nettype none
module quadrature_pd_motor_position_drive_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       CHAN_B        = 1'b1;
    localparam logic [1:0] LVL_LOW       = 2'd0;
    localparam logic [1:0] LVL_HIGH      = 2'd1;
    localparam logic [1:0] LVL_TIMEOUT   = 2'd2;
    localparam logic [1:0] LVL_SPARE     = 2'd3;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 60;
    localparam int         PHASE_ITEMS   = 185;
    localparam longint     TERM_MAX      = 64'sd35184372088831;

    class drive_scoreboard;
        bit [qpd_pkg::GAIN_W-1:0] kp;
        bit [qpd_pkg::GAIN_W-1:0] kd;
        bit                       fb_only;
        bit                       lvl_a;
        bit                       lvl_b;
        bit [qpd_pkg::OUT_W-1:0]  pos;
        longint                   prev_err;
        bit                       dir;
        bit [qpd_pkg::DUTY_W-1:0] duty;
        qpd_pkg::out_t            due_beats[$];
        int                       errors;

        function new();
            kp       = 16'd5120;
            kd       = '0;
            fb_only  = 1'b0;
            lvl_a    = 1'b0;
            lvl_b    = 1'b0;
            pos      = '0;
            prev_err = 0;
            dir      = 1'b0;
            duty     = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [qpd_pkg::CFG_IDX_W-1:0] idx,
                                logic [qpd_pkg::CFG_W-1:0] val);
            case (idx)
                qpd_pkg::CFG_GAIN_PROP:     kp = val;
                qpd_pkg::CFG_GAIN_DERIV:    kd = val;
                qpd_pkg::CFG_FEEDBACK_ONLY: fb_only = val[0];
                default: ;
            endcase
        endfunction

        function longint clamp_term(longint v);
            if (v > TERM_MAX) return TERM_MAX;
            if (v < -TERM_MAX) return -TERM_MAX;
            return v;
        endfunction

        function void take_item(qpd_pkg::in_t it);
            longint        tgt;
            longint        cur;
            longint        err;
            longint        slope;
            longint        sum;
            longint        mag;
            qpd_pkg::out_t want;
            if (it.req_type == qpd_pkg::REQ_EDGE) begin
                if (it.level <= LVL_HIGH) begin
                    if (it.channel == qpd_pkg::CHAN_A) begin
                        lvl_a = it.level[0];
                        pos = (it.level[0] != lvl_b) ? pos + 1 : pos - 1;
                    end else begin
                        lvl_b = it.level[0];
                        pos = (it.level[0] == lvl_a) ? pos + 1 : pos - 1;
                    end
                end
            end else if (!fb_only) begin
                tgt   = longint'(signed'(it.target));
                cur   = longint'(signed'(pos));
                err   = tgt - cur;
                slope = clamp_term(err - prev_err);
                sum   = longint'(kp) * clamp_term(err) + longint'(kd) * slope;
                mag   = ((sum < 0) ? -sum : sum) >> qpd_pkg::FRAC_W;
                prev_err = err;
                dir = (sum > 0);
                if (mag < qpd_pkg::DUTY_LOW)
                    duty = '0;
                else if (mag >= qpd_pkg::DUTY_HIGH)
                    duty = qpd_pkg::DUTY_W'(qpd_pkg::DUTY_MAX);
                else
                    duty = qpd_pkg::DUTY_W'((mag * qpd_pkg::DUTY_MUL + qpd_pkg::DUTY_RND)
                                            / qpd_pkg::DUTY_DIV);
            end
            want.position  = pos;
            want.direction = dir;
            want.duty      = duty;
            due_beats = {due_beats, want};
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_beat(qpd_pkg::out_t got);
            qpd_pkg::out_t want;
            if (due_beats.size() == 0) begin
                report($sformatf("unexpected beat, position %0d", got.position));
                return;
            end
            want = due_beats.pop_front();
            if (got.position !== want.position)
                report($sformatf("position got %0d want %0d", got.position, want.position));
            if (got.direction !== want.direction)
                report($sformatf("direction got %b want %b", got.direction, want.direction));
            if (got.duty !== want.duty)
                report($sformatf("duty got %0d want %0d", got.duty, want.duty));
        endtask
    endclass

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    qpd_pkg::in_t                  s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    qpd_pkg::out_t                 m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [qpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [qpd_pkg::CFG_W-1:0]     cfg_data  = '0;

    drive_scoreboard sb;
    logic steady      = 1'b0;
    bit   walk_up     = 1'b1;
    int   hold_asks   = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;
    int   stall_count = 0;

    quadrature_pd_motor_position_drive u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(m_data);
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic qpd_pkg::in_t item_of(logic req, logic chan, logic [1:0] lvl,
                                             logic [31:0] tgt);
        qpd_pkg::in_t it;
        it.req_type = req;
        it.channel  = chan;
        it.level    = lvl;
        it.target   = tgt;
        return it;
    endfunction

    // mostly clean quadrature walks, some arbitrary edges and timeouts, ticks mostly near position
    function automatic qpd_pkg::in_t random_item();
        qpd_pkg::in_t it;
        int           pick;
        pick        = $urandom_range(99);
        it.target   = $urandom;
        it.channel  = 1'($urandom_range(1));
        it.level    = 2'($urandom_range(3));
        it.req_type = qpd_pkg::REQ_EDGE;
        if (pick < 55) begin
            if ($urandom_range(15) == 0)
                walk_up = !walk_up;
            it.channel = ((sb.lvl_a == sb.lvl_b) == walk_up) ? qpd_pkg::CHAN_A : CHAN_B;
            it.level   = {1'b0, (it.channel == qpd_pkg::CHAN_A) ? !sb.lvl_a : !sb.lvl_b};
        end else if (pick >= 70) begin
            it.req_type = qpd_pkg::REQ_TICK;
            case ($urandom_range(3))
                0, 1:    it.target = sb.pos + $urandom_range(4000) - 2000;
                2:       it.target = sb.pos + $urandom_range(1 << 21) - (1 << 20);
                default: it.target = $urandom;
            endcase
        end
        return it;
    endfunction

    task automatic send_item(qpd_pkg::in_t it);
        if (!steady && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.due_beats.size() != 0);
    endtask

    task automatic write_regs(logic [qpd_pkg::CFG_W-1:0] kp, logic [qpd_pkg::CFG_W-1:0] kd,
                              logic fb);
        logic [qpd_pkg::CFG_IDX_W-1:0] idx  [3];
        logic [qpd_pkg::CFG_W-1:0]     vals [3];
        idx  = '{qpd_pkg::CFG_GAIN_PROP, qpd_pkg::CFG_GAIN_DERIV, qpd_pkg::CFG_FEEDBACK_ONLY};
        vals = '{kp, kd, {{(qpd_pkg::CFG_W-1){1'b0}}, fb}};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gains: both edge directions, timeouts, target extremes, zero drive
        send_item(item_of(qpd_pkg::REQ_EDGE, qpd_pkg::CHAN_A, LVL_HIGH, '0));
        send_item(item_of(qpd_pkg::REQ_EDGE, CHAN_B, LVL_HIGH, '0));
        send_item(item_of(qpd_pkg::REQ_EDGE, qpd_pkg::CHAN_A, LVL_LOW, '0));
        send_item(item_of(qpd_pkg::REQ_EDGE, CHAN_B, LVL_LOW, '0));
        send_item(item_of(qpd_pkg::REQ_EDGE, CHAN_B, LVL_HIGH, '1));
        send_item(item_of(qpd_pkg::REQ_EDGE, qpd_pkg::CHAN_A, LVL_HIGH, '1));
        send_item(item_of(qpd_pkg::REQ_EDGE, qpd_pkg::CHAN_A, LVL_TIMEOUT, '0));
        send_item(item_of(qpd_pkg::REQ_EDGE, CHAN_B, LVL_SPARE, '1));
        send_item(item_of(qpd_pkg::REQ_TICK, CHAN_B, LVL_SPARE, 32'h7FFF_FFFF));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, 32'h8000_0000));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos));
        send_item(item_of(qpd_pkg::REQ_TICK, CHAN_B, LVL_HIGH, 32'hFFFF_FFFF));
        drain();

        // gain 1.0 makes the magnitude equal the error: walk the duty thresholds
        write_regs(16'd1024, 16'd0, 1'b0);
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos + 124));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos + 125));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos + 1249));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos + 1250));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos - 1250));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos + 600));
        drain();

        // derivative only: a repeated error gives zero drive
        write_regs(16'd0, 16'hFFFF, 1'b0);
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos + 1000));
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, sb.pos + 1000));
        drain();

        write_regs(16'd5120, 16'd0, 1'b1);
        send_item(item_of(qpd_pkg::REQ_TICK, qpd_pkg::CHAN_A, LVL_LOW, 32'h7FFF_FFFF));
        send_item(item_of(qpd_pkg::REQ_EDGE, qpd_pkg::CHAN_A, LVL_LOW, '0));
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       write_regs(16'd0, 16'd0, 1'b0);
                1:       write_regs(16'hFFFF, 16'hFFFF, 1'b0);
                2, 5:    write_regs(qpd_pkg::CFG_W'($urandom_range(65535)),
                                    qpd_pkg::CFG_W'($urandom_range(65535)), 1'b0);
                3:       write_regs(qpd_pkg::CFG_W'($urandom_range(65535)),
                                    qpd_pkg::CFG_W'($urandom_range(65535)), 1'b1);
                4:       write_regs(16'd5120, 16'd256, 1'b0);
                default: write_regs(16'd5120, 16'd0, 1'b0);
            endcase
            steady <= (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == 20)
                    hold_asks <= hold_asks + 1;
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    drain();
                send_item(random_item());
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.due_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
design/qpd_pkg.sv
design/qpd_duty_map.sv
design/quadrature_pd_motor_position_drive.sv
verif/quadrature_pd_motor_position_drive_test.sv
